[hdl/gn_pkg.sv]
// Package for the gradient noise evaluator: permutation ROM, widths and dimension codes.
package gn_pkg;

  localparam int FracBitsDefault = 16;
  localparam int NoiseW = 19;

  localparam logic [1:0] DIM_1D = 2'd1;
  localparam logic [1:0] DIM_2D = 2'd2;
  localparam logic [1:0] DIM_3D = 2'd3;

  typedef logic [7:0] perm_tab_t [256];

  // Permutation table, built at elaboration by the shuffle
  function automatic perm_tab_t build_perm();
    perm_tab_t p;
    logic [31:0] s;
    logic [31:0] r;
    logic [31:0] j;
    logic [7:0] tmp;
    s = 32'd1;
    for (int k = 0; k < 256; k++) p[k] = k[7:0];
    for (int i = 255; i > 0; i--) begin
      s = s * 32'd214013 + 32'd2531011;
      r = (s >> 16) & 32'h7fff;
      j = ((r * (i + 1)) >> 15) & 32'd255;
      tmp = p[i];
      p[i] = p[j[7:0]];
      p[j[7:0]] = tmp;
    end
    return p;
  endfunction

  localparam perm_tab_t PERM = build_perm();

  function automatic logic [7:0] perm_lookup(input logic [7:0] k);
    return PERM[k];
  endfunction

endpackage

[hdl/gradient_noise_1d_2d_3d.sv]
// Top level of the gradient noise evaluator, a fully pipelined datapath.
// Nine register stages, the first loaded at the accepting edge, output register included.
// Throughput: one point per cycle; the pipeline advances whenever the output is free
// or taken, so a stall holds every stage without loss.
// Reset (rst, synchronous) clears valid bits and sets dimensions to 3.
module gradient_noise_1d_2d_3d #(
  parameter int FRAC_BITS = gn_pkg::FracBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       x_coord,
  input  logic signed [31:0]       y_coord,
  input  logic signed [31:0]       z_coord,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [gn_pkg::NoiseW-1:0] noise_value
);

  localparam int FW = FRAC_BITS;
  localparam int OW = FW + 3;   // offsets and gradients in [-2, 2]
  localparam int TW = FW + 1;   // fade in [0, ONE]
  localparam int VW = FW + 4;   // blended values
  localparam int NS = 9;
  localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

  // Configuration register
  logic [1:0] dimensions;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, dimensions} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= gn_pkg::DIM_3D;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      dimensions <= pwdata[1:0];
    end
  end

  // Pipeline enable: all stages move together
  logic adv;
  logic [NS-1:0] vld;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end
  assign out_valid = vld[NS-1];

  // Low four bits of a permutation entry
  function automatic logic [3:0] hash4(input logic [7:0] k);
    logic [7:0] p;
    p = gn_pkg::perm_lookup(k);
    return p[3:0];
  endfunction

  // Stage 1: split, mode latch, first hash level
  logic [1:0] s1_dim;
  logic [7:0] s1_l1, s1_l2, s1_i0, s1_i1;
  logic [FW-1:0] s1_fx, s1_fy, s1_fz;
  logic [7:0] lx, ly, lz;
  assign lx = x_coord[FW +: 8];
  assign ly = y_coord[FW +: 8];
  assign lz = z_coord[FW +: 8];
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dim <= (dimensions == 2'd0) ? gn_pkg::DIM_3D : dimensions;
      s1_l1 <= ly;
      s1_l2 <= lz;
      s1_fx <= x_coord[FW-1:0];
      s1_fy <= y_coord[FW-1:0];
      s1_fz <= z_coord[FW-1:0];
      s1_i0 <= gn_pkg::perm_lookup(lx);
      s1_i1 <= gn_pkg::perm_lookup(lx + 8'd1);
    end
  end

  // Stage 2: second hash level, squares of fractions
  logic [1:0] s2_dim;
  logic [7:0] s2_l2;
  logic [7:0] s2_a [4];
  logic [FW-1:0] s2_fx, s2_fy, s2_fz;
  logic [FW-1:0] s2_f2x, s2_f2y, s2_f2z;
  logic [2*FW-1:0] sqx, sqy, sqz;
  assign sqx = s1_fx * s1_fx;
  assign sqy = s1_fy * s1_fy;
  assign sqz = s1_fz * s1_fz;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dim <= s1_dim;
      s2_l2 <= s1_l2;
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
      s2_fz <= s1_fz;
      s2_f2x <= sqx[2*FW-1:FW];
      s2_f2y <= sqy[2*FW-1:FW];
      s2_f2z <= sqz[2*FW-1:FW];
      // in 1D the second level hashes the x index alone
      s2_a[0] <= gn_pkg::perm_lookup(s1_i0 + s1_l1);
      s2_a[1] <= gn_pkg::perm_lookup(s1_i1 + s1_l1);
      s2_a[2] <= gn_pkg::perm_lookup(s1_i0 + s1_l1 + 8'd1);
      s2_a[3] <= gn_pkg::perm_lookup(s1_i1 + s1_l1 + 8'd1);
      if (s1_dim == gn_pkg::DIM_1D) begin
        s2_a[0] <= gn_pkg::perm_lookup(s1_i0);
        s2_a[1] <= gn_pkg::perm_lookup(s1_i1);
      end
    end
  end

  // Stage 3: corner hashes, fade products
  logic [1:0] s3_dim;
  logic [3:0] s3_h [8];
  logic [FW-1:0] s3_fx, s3_fy, s3_fz;
  logic [TW-1:0] s3_tx, s3_ty, s3_tz;
  logic [FW+2:0] wx, wy, wz;     // 3*ONE; 2f is subtracted in the product
  logic [2*FW+2:0] px, py, pz;
  assign wx = (FW+3)'(3) << FW;
  assign wy = wx;
  assign wz = wx;
  assign px = (wx - {2'b0, s2_fx, 1'b0}) * s2_f2x;
  assign py = (wy - {2'b0, s2_fy, 1'b0}) * s2_f2y;
  assign pz = (wz - {2'b0, s2_fz, 1'b0}) * s2_f2z;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_dim <= s2_dim;
      s3_fx <= s2_fx;
      s3_fy <= s2_fy;
      s3_fz <= s2_fz;
      s3_tx <= px[FW +: TW];
      s3_ty <= py[FW +: TW];
      s3_tz <= pz[FW +: TW];
      for (int c = 0; c < 4; c++) begin
        if (s2_dim == gn_pkg::DIM_3D) begin
          s3_h[c]   <= hash4(s2_a[c] + s2_l2);
          s3_h[c+4] <= hash4(s2_a[c] + s2_l2 + 8'd1);
        end else begin
          s3_h[c]   <= hash4(s2_a[c]);
          s3_h[c+4] <= 4'd0;
        end
      end
    end
  end

  // Gradient of one corner
  function automatic logic signed [OW-1:0] grad(input logic [3:0] h,
      input logic signed [OW-1:0] x, input logic signed [OW-1:0] y,
      input logic signed [OW-1:0] z);
    logic signed [OW-1:0] g;
    case (h)
      4'd0, 4'd12: g = x + y;
      4'd1, 4'd13: g = -x + y;
      4'd2:        g = x - y;
      4'd3:        g = -x - y;
      4'd4:        g = x + z;
      4'd5:        g = -x + z;
      4'd6:        g = x - z;
      4'd7:        g = -x - z;
      4'd8:        g = y + z;
      4'd9:        g = -y + z;
      4'd10, 4'd14: g = y - z;
      default:     g = -y - z;
    endcase
    return g;
  endfunction

  // Stage 4: corner gradients
  logic signed [OW-1:0] ox0, ox1, oy0, oy1, oz0, oz1;
  always_comb begin
    ox0 = OW'(s3_fx);
    ox1 = OW'(s3_fx) - OW'(ONE);
    oy0 = (s3_dim == gn_pkg::DIM_1D) ? '0 : OW'(s3_fy);
    oy1 = (s3_dim == gn_pkg::DIM_1D) ? '0 : OW'(s3_fy) - OW'(ONE);
    oz0 = (s3_dim == gn_pkg::DIM_3D) ? OW'(s3_fz) : '0;
    oz1 = (s3_dim == gn_pkg::DIM_3D) ? OW'(s3_fz) - OW'(ONE) : '0;
  end
  logic [1:0] s4_dim;
  logic signed [VW-1:0] s4_g [8];
  logic [TW-1:0] s4_tx, s4_ty, s4_tz;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dim <= s3_dim;
      s4_tx <= s3_tx;
      s4_ty <= s3_ty;
      s4_tz <= s3_tz;
      s4_g[0] <= VW'(grad(s3_h[0], ox0, oy0, oz0));
      s4_g[1] <= VW'(grad(s3_h[1], ox1, oy0, oz0));
      s4_g[2] <= VW'(grad(s3_h[2], ox0, oy1, oz0));
      s4_g[3] <= VW'(grad(s3_h[3], ox1, oy1, oz0));
      s4_g[4] <= VW'(grad(s3_h[4], ox0, oy0, oz1));
      s4_g[5] <= VW'(grad(s3_h[5], ox1, oy0, oz1));
      s4_g[6] <= VW'(grad(s3_h[6], ox0, oy1, oz1));
      s4_g[7] <= VW'(grad(s3_h[7], ox1, oy1, oz1));
    end
  end

  // Blend is split: product stage then add stage
  localparam int PW = VW + TW + 1;
  function automatic logic signed [PW-1:0] bprod(input logic signed [VW-1:0] a,
      input logic signed [VW-1:0] b, input logic [TW-1:0] t);
    logic signed [VW:0] d;
    d = (VW+1)'(b) - (VW+1)'(a);
    return PW'(d * $signed({1'b0, t}));
  endfunction
  function automatic logic signed [VW-1:0] badd(input logic signed [VW-1:0] a,
      input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = p >>> FW;                 // arithmetic shift = floor
    return a + VW'(q);
  endfunction

  // Stage 5: x products
  logic [1:0] s5_dim;
  logic signed [VW-1:0] s5_a [4];
  logic signed [PW-1:0] s5_p [4];
  logic [TW-1:0] s5_ty, s5_tz;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dim <= s4_dim;
      s5_ty <= s4_ty;
      s5_tz <= s4_tz;
      for (int k = 0; k < 4; k++) begin
        s5_a[k] <= s4_g[2*k];
        s5_p[k] <= bprod(s4_g[2*k], s4_g[2*k+1], s4_tx);
      end
    end
  end

  // Stage 6: x blends added, y products
  logic [1:0] s6_dim;
  logic signed [VW-1:0] s6_a [2];
  logic signed [PW-1:0] s6_p [2];
  logic signed [VW-1:0] s6_x1d;
  logic [TW-1:0] s6_tz;
  logic signed [VW-1:0] bx [4];
  always_comb begin
    for (int k = 0; k < 4; k++) bx[k] = badd(s5_a[k], s5_p[k]);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_dim <= s5_dim;
      s6_tz <= s5_tz;
      s6_x1d <= bx[0];
      s6_a[0] <= bx[0];
      s6_a[1] <= bx[2];
      s6_p[0] <= bprod(bx[0], bx[1], s5_ty);
      s6_p[1] <= bprod(bx[2], bx[3], s5_ty);
    end
  end

  // Stage 7: y blends
  logic [1:0] s7_dim;
  logic signed [VW-1:0] s7_b0, s7_b1, s7_x1d;
  logic [TW-1:0] s7_tz;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_dim <= s6_dim;
      s7_tz <= s6_tz;
      s7_x1d <= s6_x1d;
      s7_b0 <= badd(s6_a[0], s6_p[0]);
      s7_b1 <= badd(s6_a[1], s6_p[1]);
    end
  end

  // Stage 8: z product
  logic [1:0] s8_dim;
  logic signed [VW-1:0] s8_a, s8_x1d;
  logic signed [PW-1:0] s8_p;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_dim <= s7_dim;
      s8_x1d <= s7_x1d;
      s8_a <= s7_b0;
      s8_p <= bprod(s7_b0, s7_b1, s7_tz);
    end
  end

  // Stage 9: final select into the output register
  logic signed [VW-1:0] res;
  always_comb begin
    case (s8_dim)
      gn_pkg::DIM_1D: res = s8_x1d;
      gn_pkg::DIM_2D: res = s8_a;
      default:        res = badd(s8_a, s8_p);
    endcase
  end
  // sign-extended for narrow fractions, low bits kept for wide ones
  always_ff @(posedge clk) begin
    if (adv) noise_value <= gn_pkg::NoiseW'(res);
  end

endmodule

[hdl/gn_checker.sv]
// Port-level checker for the gradient noise evaluator, bound to the top level.
module gn_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready,
  input logic [18:0] noise_value
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("result changed while stalled");

  // input side only stalls when output is stalled
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // nothing appears straight out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind gradient_noise_1d_2d_3d gn_checker u_gn_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pready(pready),
  .noise_value(noise_value)
);

[tb/sv/testbench.sv]
// Testbench for the gradient noise evaluator: directed table, random points, predictor check.
`timescale 1ns / 1ps

module testbench;

  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] ADDR_DIMENSIONS = 2'd0;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic signed [31:0] x_coord, y_coord, z_coord;
  logic out_valid, out_ready;
  logic signed [gn_pkg::NoiseW-1:0] noise_value;

  gradient_noise_1d_2d_3d dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .x_coord(x_coord), .y_coord(y_coord),
    .z_coord(z_coord), .out_valid(out_valid), .out_ready(out_ready),
    .noise_value(noise_value)
  );

  // Predictor's own copy of the hash table and setting
  logic [7:0] hash_tab [256];
  logic [1:0] dim_setting;
  logic [gn_pkg::NoiseW-1:0] noise_expected [$];
  int errors;
  int idle_cycles;
  bit long_hold;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    logic [gn_pkg::NoiseW-1:0] noise;
  } point_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shuffle of the identity, driven by an LCG
  task automatic make_hash_tab();
    logic [31:0] s, r, j;
    logic [7:0] tmp;
    s = 32'd1;
    for (int k = 0; k < 256; k++) hash_tab[k] = k[7:0];
    for (int i = 255; i > 0; i--) begin
      s = s * 32'd214013 + 32'd2531011;
      r = (s >> 16) & 32'h7fff;
      j = ((r * (i + 1)) >> 15) & 32'd255;
      tmp = hash_tab[i];
      hash_tab[i] = hash_tab[j[7:0]];
      hash_tab[j[7:0]] = tmp;
    end
  endtask

  function automatic longint fade_curve(longint f);
    longint f2;
    f2 = (f * f) >>> FB;
    return (((longint'(3) << FB) - 2 * f) * f2) >>> FB;
  endfunction

  function automatic longint grad_sum(logic [7:0] h, longint x, longint y, longint z);
    case (h[3:0])
      4'd0, 4'd12: return x + y;
      4'd1, 4'd13: return -x + y;
      4'd2: return x - y;
      4'd3: return -x - y;
      4'd4: return x + z;
      4'd5: return -x + z;
      4'd6: return x - z;
      4'd7: return -x - z;
      4'd8: return y + z;
      4'd9: return -y + z;
      4'd10, 4'd14: return y - z;
      default: return -y - z;
    endcase
  endfunction

  // Arithmetic shift of a signed longint floors toward minus infinity
  function automatic longint lerp_fx(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> FB);
  endfunction

  function automatic logic [gn_pkg::NoiseW-1:0] noise_at(logic [31:0] xr, logic [31:0] yr,
                                                         logic [31:0] zr, logic [1:0] dm);
    longint one, fx, fy, fz, t0, t1, t2, r, b0, b1;
    logic [7:0] l0, l1, l2, i0, i1, a0, a1, a2, a3;
    one = longint'(1) << FB;
    l0 = xr[FB+7:FB]; l1 = yr[FB+7:FB]; l2 = zr[FB+7:FB];
    fx = xr[FB-1:0]; fy = yr[FB-1:0]; fz = zr[FB-1:0];
    t0 = fade_curve(fx); t1 = fade_curve(fy); t2 = fade_curve(fz);
    if (dm == gn_pkg::DIM_1D) begin
      r = lerp_fx(grad_sum(hash_tab[hash_tab[hash_tab[l0]]], fx, 0, 0),
                  grad_sum(hash_tab[hash_tab[hash_tab[8'(l0 + 1)]]], fx - one, 0, 0), t0);
    end else begin
      i0 = hash_tab[l0]; i1 = hash_tab[8'(l0 + 1)];
      a0 = hash_tab[8'(i0 + l1)]; a2 = hash_tab[8'(i0 + l1 + 1)];
      a1 = hash_tab[8'(i1 + l1)]; a3 = hash_tab[8'(i1 + l1 + 1)];
      if (dm == gn_pkg::DIM_2D) begin
        r = lerp_fx(lerp_fx(grad_sum(hash_tab[a0], fx, fy, 0),
                            grad_sum(hash_tab[a1], fx - one, fy, 0), t0),
                    lerp_fx(grad_sum(hash_tab[a2], fx, fy - one, 0),
                            grad_sum(hash_tab[a3], fx - one, fy - one, 0), t0), t1);
      end else begin
        b0 = lerp_fx(lerp_fx(grad_sum(hash_tab[8'(a0 + l2)], fx, fy, fz),
                             grad_sum(hash_tab[8'(a1 + l2)], fx - one, fy, fz), t0),
                     lerp_fx(grad_sum(hash_tab[8'(a2 + l2)], fx, fy - one, fz),
                             grad_sum(hash_tab[8'(a3 + l2)], fx - one, fy - one, fz), t0),
                     t1);
        b1 = lerp_fx(lerp_fx(grad_sum(hash_tab[8'(a0 + l2 + 1)], fx, fy, fz - one),
                             grad_sum(hash_tab[8'(a1 + l2 + 1)], fx - one, fy, fz - one),
                             t0),
                     lerp_fx(grad_sum(hash_tab[8'(a2 + l2 + 1)], fx, fy - one, fz - one),
                             grad_sum(hash_tab[8'(a3 + l2 + 1)], fx - one, fy - one,
                                      fz - one), t0), t1);
        r = lerp_fx(b0, b1, t2);
      end
    end
    return r[gn_pkg::NoiseW-1:0];
  endfunction

  // Register write: setup then access cycle
  task automatic write_dimensions(logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_DIMENSIONS; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    dim_setting = value[1:0];
  endtask

  // valid stays high into the next request when no gap is drawn
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit known, logic [gn_pkg::NoiseW-1:0] noise);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; x_coord <= x; y_coord <= y; z_coord <= z;
    do @(posedge clk); while (!in_ready);
    noise_expected.push_back(known ? noise : noise_at(x, y, z, dim_setting));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      2: return {16'($urandom_range(0, 1) ? 16'hffff : 16'h0000), 16'($urandom())};
      default: return 32'({$urandom(), 16'h0000} >> 16 | {16'($urandom()), 16'h0});
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold && !hold_taken) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_taken = 1'b1;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected noise_value %0d", $time, noise_value);
        errors++;
      end else begin
        if (noise_value !== noise_expected[0]) begin
          $display("%0t: noise_value expected %0d actual %0d", $time,
                   $signed(noise_expected[0]), noise_value);
          errors++;
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    point_row_t rows [$];
    logic [1:0] dims [6];
    rst = 1'b1; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; x_coord = '0; y_coord = '0; z_coord = '0;
    long_hold = 1'b0;
    make_hash_tab();
    dim_setting = gn_pkg::DIM_3D;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lattice points give zero, plus extremes and wraps
    rows = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, '0},
      '{32'h0001_0000, 32'h0005_0000, 32'hfff0_0000, 1'b1, '0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'hffff_ffff, 32'h0000_0001, 32'hffff_8000, 1'b0, '0},
      '{32'h00ff_8000, 32'h00ff_4000, 32'h00ff_c000, 1'b0, '0},
      '{32'hffff_0000, 32'h00ff_0000, 32'h8000_0000, 1'b1, '0},
      '{32'h5555_aaaa, 32'haaaa_5555, 32'h0f0f_f0f0, 1'b0, '0}
    };
    dims = '{gn_pkg::DIM_3D, gn_pkg::DIM_1D, gn_pkg::DIM_2D, 2'd0, gn_pkg::DIM_3D,
             gn_pkg::DIM_1D};
    foreach (rows[k]) send_point(rows[k].x, rows[k].y, rows[k].z, rows[k].known, '0);
    drain();
    for (int d = 1; d < 5; d++) begin
      write_dimensions(32'(dims[d]));
      foreach (rows[k]) send_point(rows[k].x, rows[k].y, rows[k].z, rows[k].known, '0);
      drain();
    end

    // Random phases across settings; long stall in the second
    for (int ph = 0; ph < 6; ph++) begin
      write_dimensions(32'(ph == 5 ? $urandom_range(0, 3) : dims[ph]));
      if (ph == 1) long_hold = 1'b1;
      for (int n = 0; n < 115; n++) begin
        if (ph == 1 && n < 30) begin
          in_valid <= 1'b1; x_coord <= rand_coord(); y_coord <= rand_coord();
          z_coord <= rand_coord();
          do @(posedge clk); while (!in_ready);
          noise_expected.push_back(noise_at(x_coord, y_coord, z_coord, dim_setting));
        end else begin
          send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
        end
      end
      drain();
    end

    if (errors == 0 && noise_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
